// ----- hdl/nfc_response_frame_deframer_macros.svh -----
// ----------------------------------------------------------------------------
// NFC response frame deframer assertion macros
// Shared concurrent assertion wrappers, clocked on clk and held off in rst.
// ----------------------------------------------------------------------------
`ifndef NFC_RESPONSE_FRAME_DEFRAMER_MACROS_SVH
`define NFC_RESPONSE_FRAME_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define NFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// expression must never be true outside reset
`define NFC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`else

`define NFC_ASSERT(lbl, prop, msg)
`define NFC_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ----- hdl/nfc_rfd_pkg.sv -----
// ----------------------------------------------------------------------------
// NFC response frame deframer package
// Transaction types, status codes, register indexes and frame constants.
// ----------------------------------------------------------------------------
`default_nettype none

package nfc_rfd_pkg;

  // input transaction: received byte or link timeout
  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } item_t;

  // output transaction: payload byte or end of frame status
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic [7:0] payload_length;
  } result_t;

  // item mode
  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  // result kind
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_NOSPACE = 2'd3;

  // configuration register indexes
  localparam logic CFG_SENT_COMMAND = 1'b0;
  localparam logic CFG_MAX_PAYLOAD  = 1'b1;

  // register reset values
  localparam logic [7:0] SENT_COMMAND_RST = 8'd0;
  localparam logic [7:0] MAX_PAYLOAD_RST  = 8'd64;

  // frame constants
  localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
  localparam logic [7:0] START_CODE    = 8'hFF;
  localparam logic [7:0] TFI_IN        = 8'hD5;
  localparam logic [7:0] LEN_OVERHEAD  = 8'd2;
  localparam logic [7:0] POSTAMBLE     = 8'h00;

endpackage

`default_nettype wire

// ----- hdl/nfc_response_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// NFC response frame deframer
// Parses 00 00 FF LEN LCS D5 CMD+1 payload DCS 00, passes payload bytes out
// and closes each frame with one status transaction.
// ----------------------------------------------------------------------------
// Each result is registered in the output register, or in the skid while the output is stalled.
// Throughput: one item per cycle while the skid is empty; the parser state updates in a single pass.
// A one-entry skid register lets items keep flowing while a result waits.
// Reset (rst, synchronous): parser back to waiting for a preamble byte,
// output and skid emptied, sent_command = 0, max_payload = 64.
`default_nettype none

`include "nfc_response_frame_deframer_macros.svh"

module nfc_response_frame_deframer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // received bytes
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire nfc_rfd_pkg::item_t   item,
  // payload bytes and status
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output nfc_rfd_pkg::result_t      result,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,
  input  wire logic [7:0]           cfg_data
);

  typedef enum logic [3:0] {
    PH_PRE0,
    PH_PRE1,
    PH_PRE2,
    PH_LEN,
    PH_LCS,
    PH_TFI,
    PH_CODE,
    PH_DATA,
    PH_DCS,
    PH_POST
  } phase_t;

  // configuration registers
  logic [7:0] sent_command;
  logic [7:0] max_payload;

  // parser state
  phase_t     phase, phase_next;
  logic       group_bad, group_bad_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;

  // output register and skid
  logic                 skid_valid;
  nfc_rfd_pkg::result_t skid;

  logic                 item_accept;
  logic                 result_take;
  logic                 res_emit;
  nfc_rfd_pkg::result_t res;
  logic [7:0]           rx;
  logic [7:0]           sum_add;
  logic [7:0]           len_net;
  logic [7:0]           left_dec;

  assign cfg_ready   = 1'b1;
  assign item_stall  = skid_valid;
  assign item_accept = item_valid & ~item_stall;
  assign result_take = result_valid & ~result_stall;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      sent_command <= nfc_rfd_pkg::SENT_COMMAND_RST;
      max_payload  <= nfc_rfd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nfc_rfd_pkg::CFG_SENT_COMMAND: sent_command <= cfg_data;
        nfc_rfd_pkg::CFG_MAX_PAYLOAD:  max_payload  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx       = item.rx_byte;
  assign sum_add  = running_sum + rx;
  assign len_net  = frame_length - nfc_rfd_pkg::LEN_OVERHEAD;
  assign left_dec = bytes_left - 8'd1;

  // frame parser: next state and result for the current item
  always_comb begin
    phase_next        = phase;
    group_bad_next    = group_bad;
    frame_length_next = frame_length;
    bytes_left_next   = bytes_left;
    running_sum_next  = running_sum;
    res_emit          = 1'b0;
    res               = '0;

    if (item.mode == nfc_rfd_pkg::MODE_TIMEOUT) begin
      res_emit   = 1'b1;
      res.kind   = nfc_rfd_pkg::KIND_STATUS;
      res.status = nfc_rfd_pkg::ST_TIMEOUT;
    end else begin
      case (phase)
        PH_PRE0: begin
          group_bad_next = (rx != nfc_rfd_pkg::PREAMBLE_BYTE);
          phase_next     = PH_PRE1;
        end
        PH_PRE1: begin
          if (rx != nfc_rfd_pkg::PREAMBLE_BYTE) group_bad_next = 1'b1;
          phase_next = PH_PRE2;
        end
        PH_PRE2: begin
          if (rx != nfc_rfd_pkg::START_CODE || group_bad) begin
            res_emit   = 1'b1;
            res.kind   = nfc_rfd_pkg::KIND_STATUS;
            res.status = nfc_rfd_pkg::ST_INVALID;
          end else begin
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          running_sum_next  = rx;
          frame_length_next = rx;
          phase_next        = PH_LCS;
        end
        PH_LCS: begin
          if (sum_add != 8'd0 || frame_length < nfc_rfd_pkg::LEN_OVERHEAD) begin
            res_emit   = 1'b1;
            res.kind   = nfc_rfd_pkg::KIND_STATUS;
            res.status = nfc_rfd_pkg::ST_INVALID;
          end else if (len_net > max_payload) begin
            res_emit   = 1'b1;
            res.kind   = nfc_rfd_pkg::KIND_STATUS;
            res.status = nfc_rfd_pkg::ST_NOSPACE;
          end else begin
            frame_length_next = len_net;
            bytes_left_next   = len_net;
            group_bad_next    = 1'b0;
            phase_next        = PH_TFI;
          end
        end
        PH_TFI: begin
          group_bad_next   = (rx != nfc_rfd_pkg::TFI_IN);
          running_sum_next = rx;
          phase_next       = PH_CODE;
        end
        PH_CODE: begin
          if (group_bad || rx != sent_command + 8'd1) begin
            res_emit   = 1'b1;
            res.kind   = nfc_rfd_pkg::KIND_STATUS;
            res.status = nfc_rfd_pkg::ST_INVALID;
          end else begin
            running_sum_next = sum_add;
            phase_next       = (bytes_left != 8'd0) ? PH_DATA : PH_DCS;
          end
        end
        PH_DATA: begin
          running_sum_next = sum_add;
          bytes_left_next  = left_dec;
          if (left_dec == 8'd0) phase_next = PH_DCS;
          res_emit         = 1'b1;
          res.kind         = nfc_rfd_pkg::KIND_BYTE;
          res.payload_byte = rx;
        end
        PH_DCS: begin
          running_sum_next = sum_add;
          phase_next       = PH_POST;
        end
        PH_POST: begin
          res_emit = 1'b1;
          res.kind = nfc_rfd_pkg::KIND_STATUS;
          if (running_sum != 8'd0 || rx != nfc_rfd_pkg::POSTAMBLE) begin
            res.status = nfc_rfd_pkg::ST_INVALID;
          end else begin
            res.status         = nfc_rfd_pkg::ST_OK;
            res.payload_length = frame_length;
          end
        end
        default: begin
          phase_next = PH_PRE0;
        end
      endcase
    end

    // any status, or a stray phase, returns to the wait for a new frame
    if (res.kind == nfc_rfd_pkg::KIND_STATUS || phase_next == PH_PRE0) begin
      if (res_emit || phase_next == PH_PRE0) begin
        phase_next        = PH_PRE0;
        group_bad_next    = (phase == PH_PRE0 && !res_emit) ? group_bad_next : 1'b0;
        frame_length_next = (phase == PH_PRE0 && !res_emit) ? frame_length_next : 8'd0;
        bytes_left_next   = (phase == PH_PRE0 && !res_emit) ? bytes_left_next : 8'd0;
        running_sum_next  = (phase == PH_PRE0 && !res_emit) ? running_sum_next : 8'd0;
      end
    end
  end

  // parser state, output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PRE0;
      group_bad    <= 1'b0;
      frame_length <= 8'd0;
      bytes_left   <= 8'd0;
      running_sum  <= 8'd0;
      result_valid <= 1'b0;
      result       <= '0;
      skid_valid   <= 1'b0;
      skid         <= '0;
    end else begin
      if (item_accept) begin
        phase        <= phase_next;
        group_bad    <= group_bad_next;
        frame_length <= frame_length_next;
        bytes_left   <= bytes_left_next;
        running_sum  <= running_sum_next;
      end
      // output free: skid drains first, else take the new result
      if (!result_valid || result_take) begin
        if (skid_valid) begin
          result_valid <= 1'b1;
          result       <= skid;
          skid_valid   <= 1'b0;
        end else begin
          result_valid <= item_accept & res_emit;
          result       <= res;
        end
      end else if (item_accept && res_emit) begin
        skid_valid <= 1'b1;
        skid       <= res;
      end
    end
  end

  // checks
  `NFC_ASSERT(a_skid_behind_out, skid_valid |-> result_valid, "skid full with output empty")
  `NFC_ASSERT(a_data_has_bytes,
    (phase == PH_DATA) |-> (bytes_left != 8'd0), "data phase with no bytes left")
  `NFC_ASSERT(a_left_in_length, bytes_left <= frame_length, "bytes left exceeds frame length")
  `NFC_ASSERT(a_timeout_restarts,
    (item_accept && item.mode == nfc_rfd_pkg::MODE_TIMEOUT) |=> (phase == PH_PRE0),
    "timeout did not restart parser")
  `NFC_ASSERT(a_byte_status_zero,
    (result_valid && result.kind == nfc_rfd_pkg::KIND_BYTE) |->
      (result.status == nfc_rfd_pkg::ST_OK),
    "payload byte with nonzero status")

endmodule

`default_nettype wire

// ----- tb/nfc_response_frame_deframer_tb.sv -----
// ----------------------------------------------------------------------------
// NFC response frame deframer testbench
// Opens with a short table of hand-written frames, some with fixed expected
// results, then runs phases of random frames, broken frames and line noise
// under different register settings. Every accepted transaction goes through
// a cycle-free frame parser in the bench and results are compared in order.
// ----------------------------------------------------------------------------
module nfc_response_frame_deframer_tb;
  import nfc_rfd_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RST_CYCLES   = 7;
  localparam int MAX_GAP      = 16;
  localparam int LONG_HOLD    = 100;
  localparam int TAIL_CYCLES  = 4;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DIR_ROWS     = 30;
  localparam int DIR_SPLIT    = 16;
  localparam int RANDOM_ITEMS = 820;
  localparam int PHASES       = 6;
  localparam int MAX_PRINTS   = 40;

  // parser position within a frame
  typedef enum logic [3:0] {
    PH_PRE0, PH_PRE1, PH_PRE2, PH_LEN, PH_LCS,
    PH_TFI, PH_CODE, PH_DATA, PH_DCS, PH_POST
  } frame_phase_t;

  // one row of the directed table
  typedef struct packed {
    item_t   it;
    logic    fixed;
    logic    want_valid;
    result_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  item_t      item;
  logic       result_valid;
  logic       result_stall;
  result_t    result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [7:0] cfg_data;

  // bench copy of the parser state and registers
  frame_phase_t pr_phase;
  logic         pr_group_bad;
  logic [7:0]   pr_frame_len;
  logic [7:0]   pr_left;
  logic [7:0]   pr_sum;
  logic [7:0]   pr_sent_cmd;
  logic [7:0]   pr_max_payload;

  result_t  pending[$];
  dir_row_t dir_rows [DIR_ROWS];
  int       mismatches = 0;
  int       items_sent = 0;
  bit       burst      = 1'b0;
  bit       long_hold  = 1'b0;

  nfc_response_frame_deframer i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame parser
  // ---------------------------------------------------------------------------
  function automatic void restart_frame();
    pr_phase     = PH_PRE0;
    pr_group_bad = 1'b0;
    pr_frame_len = 8'h00;
    pr_left      = 8'h00;
    pr_sum       = 8'h00;
  endfunction

  function automatic result_t frame_status(input logic [1:0] st, input logic [7:0] len);
    restart_frame();
    return {KIND_STATUS, 8'h00, st, len};
  endfunction

  // advance the parser by one received byte or timeout; 1 when a result is due
  function automatic bit deframe_step(input item_t it, output result_t r);
    logic [7:0] b;
    logic [7:0] acc;
    logic [7:0] code;
    b    = it.rx_byte;
    r    = '0;
    if (it.mode == MODE_TIMEOUT) begin
      r = frame_status(ST_TIMEOUT, 8'h00);
      return 1'b1;
    end
    case (pr_phase)
      PH_PRE0: begin
        pr_group_bad = (b != PREAMBLE_BYTE);
        pr_phase     = PH_PRE1;
      end
      PH_PRE1: begin
        if (b != PREAMBLE_BYTE) pr_group_bad = 1'b1;
        pr_phase = PH_PRE2;
      end
      PH_PRE2: begin
        if (b != START_CODE || pr_group_bad) begin
          r = frame_status(ST_INVALID, 8'h00);
          return 1'b1;
        end
        pr_phase = PH_LEN;
      end
      PH_LEN: begin
        pr_sum       = b;
        pr_frame_len = b;
        pr_phase     = PH_LCS;
      end
      PH_LCS: begin
        acc = pr_sum + b;
        if (acc != 8'h00 || pr_frame_len < LEN_OVERHEAD) begin
          r = frame_status(ST_INVALID, 8'h00);
          return 1'b1;
        end
        acc = pr_frame_len - LEN_OVERHEAD;
        if (acc > pr_max_payload) begin
          r = frame_status(ST_NOSPACE, 8'h00);
          return 1'b1;
        end
        pr_frame_len = acc;
        pr_left      = acc;
        pr_group_bad = 1'b0;
        pr_phase     = PH_TFI;
      end
      PH_TFI: begin
        pr_group_bad = (b != TFI_IN);
        pr_sum       = b;
        pr_phase     = PH_CODE;
      end
      PH_CODE: begin
        code = pr_sent_cmd + 8'd1;
        if (pr_group_bad || b != code) begin
          r = frame_status(ST_INVALID, 8'h00);
          return 1'b1;
        end
        pr_sum   = pr_sum + b;
        pr_phase = (pr_left != 8'h00) ? PH_DATA : PH_DCS;
      end
      PH_DATA: begin
        pr_sum  = pr_sum + b;
        pr_left = pr_left - 8'd1;
        if (pr_left == 8'h00) pr_phase = PH_DCS;
        r = {KIND_BYTE, b, ST_OK, 8'h00};
        return 1'b1;
      end
      PH_DCS: begin
        pr_sum   = pr_sum + b;
        pr_phase = PH_POST;
      end
      PH_POST: begin
        if (pr_sum != 8'h00 || b != POSTAMBLE) r = frame_status(ST_INVALID, 8'h00);
        else r = frame_status(ST_OK, pr_frame_len);
        return 1'b1;
      end
      default: restart_frame();
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic dir_row_t byte_row(input logic [7:0] b);
    return {MODE_BYTE, b, 1'b0, 1'b0, 19'h0};
  endfunction

  function automatic dir_row_t status_row(input logic m, input logic [7:0] b,
                                          input logic [1:0] st, input logic [7:0] len);
    return {m, b, 1'b1, 1'b1, KIND_STATUS, 8'h00, st, len};
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input string what, input int got, input int want_v);
    if (mismatches < MAX_PRINTS)
      $display("%0t: result mismatch on %s: got 0x%0h, expected 0x%0h",
               $realtime, what, got, want_v);
    mismatches++;
  endtask

  // offer one transaction after a random gap (none in burst mode); entered and left at a falling edge
  task automatic offer_item(input item_t it, input bit fixed = 1'b0,
                            input bit want_valid = 1'b0, input result_t want = '0);
    int      gap;
    bit      due;
    result_t r;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    items_sent++;
    due = deframe_step(it, r);
    if (fixed) begin
      if (want_valid) pending.push_back(want);
    end else if (due) begin
      pending.push_back(r);
    end
    @(negedge clk);
  endtask

  // drop valid and wait until every result is back and the pipe has drained
  task automatic settle();
    item_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // write both registers back to back, valid held high between them
  task automatic configure(input logic [7:0] cmd, input logic [7:0] cap);
    for (int k = 0; k < 2; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (k == 0) ? CFG_SENT_COMMAND : CFG_MAX_PAYLOAD;
      cfg_data  <= (k == 0) ? cmd : cap;
      do @(posedge clk); while (!cfg_ready);
      if (k == 0) pr_sent_cmd = cmd;
      else pr_max_payload = cap;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending.size() == 0) begin
        log_mismatch("unexpected transaction", int'(result), 0);
      end else begin
        want = pending.pop_front();
        if (result.kind !== want.kind)
          log_mismatch("kind", int'(result.kind), int'(want.kind));
        if (result.payload_byte !== want.payload_byte)
          log_mismatch("payload_byte", int'(result.payload_byte), int'(want.payload_byte));
        if (result.status !== want.status)
          log_mismatch("status", int'(result.status), int'(want.status));
        if (result.payload_length !== want.payload_length)
          log_mismatch("payload_length", int'(result.payload_length),
                       int'(want.payload_length));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per transaction, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    result_stall = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        hold      = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        hold = burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    item_t      frame[$];
    item_t      tmp;
    int         len;
    int         cap;
    int         pick;
    int         fault;
    int         at;
    bit         realign;
    logic [7:0] code;
    logic [7:0] sum;
    logic [7:0] b8;
    logic [7:0] cmd;
    logic [7:0] mp;

    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_SENT_COMMAND;
    cfg_data   = 8'h00;
    restart_frame();
    pr_sent_cmd    = SENT_COMMAND_RST;
    pr_max_payload = MAX_PAYLOAD_RST;

    dir_rows = '{
      // timeout straight out of reset, byte lane ignored
      status_row(MODE_TIMEOUT, 8'hFF, ST_TIMEOUT, 8'd0),
      // good frame, one all-ones payload byte, reset registers
      byte_row(PREAMBLE_BYTE), byte_row(PREAMBLE_BYTE), byte_row(START_CODE),
      byte_row(8'h03), byte_row(8'hFD), byte_row(TFI_IN), byte_row(8'h01),
      byte_row(8'hFF), byte_row(8'h2B),
      status_row(MODE_BYTE, POSTAMBLE, ST_OK, 8'd1),
      // LEN of one with a matching LCS
      byte_row(PREAMBLE_BYTE), byte_row(PREAMBLE_BYTE), byte_row(START_CODE),
      byte_row(8'h01),
      status_row(MODE_BYTE, 8'hFF, ST_INVALID, 8'd0),
      // registers now FF / 0: empty payload, response code wraps to 00
      byte_row(PREAMBLE_BYTE), byte_row(PREAMBLE_BYTE), byte_row(START_CODE),
      byte_row(8'h02), byte_row(8'hFE), byte_row(TFI_IN), byte_row(8'h00),
      byte_row(8'h2B),
      status_row(MODE_BYTE, POSTAMBLE, ST_OK, 8'd0),
      // one payload byte against zero capacity
      byte_row(PREAMBLE_BYTE), byte_row(PREAMBLE_BYTE), byte_row(START_CODE),
      byte_row(8'h03),
      status_row(MODE_BYTE, 8'hFD, ST_NOSPACE, 8'd0)
    };

    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed frames
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_SPLIT) begin
        settle();
        configure(8'hFF, 8'h00);
      end
      offer_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].want_valid,
                 dir_rows[i].want);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      cmd = (p == 0) ? 8'h00 : (p == 2) ? 8'hFF : 8'($urandom);
      mp  = (p == 0) ? 8'd253 : (p == 1) ? 8'd0 : 8'($urandom_range(1, 80));
      configure(cmd, mp);
      burst = (p == 3);
      if (p == 2) long_hold = 1'b1;
      while (items_sent < DIR_ROWS + (p + 1) * RANDOM_ITEMS / PHASES) begin
        frame.delete();
        if ($urandom_range(0, 7) == 0) begin
          // line noise, then a timeout to get back in step
          repeat ($urandom_range(1, 6)) begin
            tmp.mode    = ($urandom_range(0, 3) == 0) ? MODE_TIMEOUT : MODE_BYTE;
            tmp.rx_byte = 8'($urandom);
            frame.push_back(tmp);
          end
          frame.push_back({MODE_TIMEOUT, 8'($urandom)});
        end else begin
          // payload size: mostly short, now and then up to or past capacity
          cap  = int'(pr_max_payload);
          pick = $urandom_range(0, 19);
          if (pick == 0) len = $urandom_range(0, cap);
          else if (pick == 1) len = (cap < 253) ? cap + 1 : cap;
          else len = $urandom_range(0, (cap < 8) ? cap : 8);
          code = pr_sent_cmd + 8'd1;
          b8   = 8'(len + 2);
          frame.push_back({MODE_BYTE, PREAMBLE_BYTE});
          frame.push_back({MODE_BYTE, PREAMBLE_BYTE});
          frame.push_back({MODE_BYTE, START_CODE});
          frame.push_back({MODE_BYTE, b8});
          frame.push_back({MODE_BYTE, 8'h00 - b8});
          frame.push_back({MODE_BYTE, TFI_IN});
          frame.push_back({MODE_BYTE, code});
          sum = TFI_IN + code;
          for (int k = 0; k < len; k++) begin
            b8  = 8'($urandom);
            sum = sum + b8;
            frame.push_back({MODE_BYTE, b8});
          end
          frame.push_back({MODE_BYTE, 8'h00 - sum});
          frame.push_back({MODE_BYTE, POSTAMBLE});

          // about a third of the frames get one fault
          realign = (len > cap);
          at      = -1;
          fault   = $urandom_range(0, 23);
          case (fault)
            0: begin
              at      = $urandom_range(0, 2);
              realign = 1'b1;
            end
            1: begin
              at      = 4;
              realign = 1'b1;
            end
            2: begin
              // too short a length, checksum still good
              b8       = 8'($urandom_range(0, 1));
              frame[3] = {MODE_BYTE, b8};
              frame[4] = {MODE_BYTE, 8'h00 - b8};
              realign  = 1'b1;
            end
            3, 4: begin
              at      = fault + 2;
              realign = 1'b1;
            end
            5: at = 7 + len;
            6: at = 8 + len;
            7: begin
              // link drops somewhere inside the frame
              pick = $urandom_range(0, frame.size() - 1);
              while (frame.size() > pick) void'(frame.pop_back());
              frame.push_back({MODE_TIMEOUT, 8'($urandom)});
            end
            default: ;
          endcase
          if (at >= 0) begin
            tmp         = frame[at];
            tmp.rx_byte = tmp.rx_byte ^ (8'h01 << $urandom_range(0, 7));
            frame[at]   = tmp;
          end
          if (realign) frame.push_back({MODE_TIMEOUT, 8'($urandom)});
        end
        foreach (frame[i]) offer_item(frame[i]);
      end
    end

    settle();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/nfc_rfd_pkg.sv
hdl/nfc_response_frame_deframer.sv
tb/nfc_response_frame_deframer_tb.sv
